@@ hdl/sawa_pkg.sv @@
// ----------------------------------------------------------------------------
// sawa_pkg
// Shared types, codes and reset constants of the stop-and-wait ARQ engine.
// ----------------------------------------------------------------------------
package sawa_pkg;

  // Default sizes
  localparam int unsigned QueueBytesDef  = 1024;
  localparam int unsigned MaxMessagesDef = 64;

  // Field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned SeqW    = 16;
  localparam int unsigned LenW    = 10;
  localparam int unsigned ActionW = 3;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 2;

  // Reset values of the configuration registers
  localparam logic [15:0] MinRetryRst    = 16'd1000;
  localparam logic [19:0] MaxRetryRst    = 20'd60000;
  localparam logic [14:0] DupTolRst      = 15'd10;
  localparam logic [19:0] LinkTimeoutRst = 20'd60000;

  // Protocol constants
  localparam logic [31:0] AckBackdateMs = 32'd10000;
  localparam logic [10:0] HeaderBytes   = 11'd2;
  // ceil(2^26 / 5): exact floor(x / 5) for x below 2^23
  localparam int unsigned RecipShift    = 26;
  localparam logic [23:0] RecipFive     = 24'd13421773;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RETRY_FLOOR  = 2'd0,
    REG_RETRY_CAP    = 2'd1,
    REG_DUP_TOL      = 2'd2,
    REG_LINK_TIMEOUT = 2'd3
  } reg_idx_e;

  // Raw event codes on the input
  typedef enum logic [KindW-1:0] {
    EV_TICK  = 3'd0,
    EV_ACK   = 3'd1,
    EV_DATA  = 3'd2,
    EV_ENQ   = 3'd3,
    EV_FLUSH = 3'd4
  } ev_code_e;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ACK,
    OP_DATA,
    OP_ENQ,
    OP_FLUSH,
    OP_NONE
  } op_e;

  // Result actions
  typedef enum logic [ActionW-1:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND      = 3'd1,
    ACT_ACK_NEW   = 3'd2,
    ACT_ACK_DUP   = 3'd3,
    ACT_DELIVERED = 3'd4,
    ACT_ACK_IGN   = 3'd5,
    ACT_QUEUED    = 3'd6,
    ACT_FULL      = 3'd7
  } action_e;

  // One classified item in the front/back queue
  typedef struct packed {
    op_e             op;
    logic [SeqW-1:0] seq;
    logic [LenW-1:0] len;
    logic            peer;
  } item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [15:0] retry_floor;
    logic [19:0] retry_cap;
    logic [14:0] dup_tol;
    logic [19:0] link_timeout;
  } cfg_t;

endpackage

@@ hdl/sawa_front.sv @@
// ----------------------------------------------------------------------------
// sawa_front
// Accepts input beats, classifies the event code and holds the items in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sawa_front import sawa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [SeqW-1:0]  seq_i,
  input  logic [LenW-1:0]  msg_length_i,
  input  logic             peer_known_i,
  output logic             item_valid_o,
  input  logic             item_pop_i,
  output item_t            item_o
);

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      cls;

  // Classify the raw event code
  always_comb begin
    cls.seq  = seq_i;
    cls.len  = msg_length_i;
    cls.peer = peer_known_i;
    case (kind_i)
      EV_TICK:  cls.op = OP_TICK;
      EV_ACK:   cls.op = OP_ACK;
      EV_DATA:  cls.op = OP_DATA;
      EV_ENQ:   cls.op = OP_ENQ;
      EV_FLUSH: cls.op = OP_FLUSH;
      default:  cls.op = OP_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

endmodule

@@ hdl/sawa_back.sv @@
// ----------------------------------------------------------------------------
// sawa_back
// Carries out one classified item per cycle unless stalled: timers, backoff,
// transmit queue of message lengths, duplicate check, registered result beat.
// ----------------------------------------------------------------------------
module sawa_back import sawa_pkg::*; #(
  parameter int unsigned QUEUE_BYTES  = QueueBytesDef,
  parameter int unsigned MAX_MESSAGES = MaxMessagesDef,
  localparam int unsigned CntW = $clog2(MAX_MESSAGES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  input  item_t               item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ActionW-1:0]  action_o,
  output logic [SeqW-1:0]     out_seq_o,
  output logic [15:0]         attempt_count_o,
  output logic [31:0]         total_retries_o,
  output logic                link_up_o,
  output logic [CntW-1:0]     pending_messages_o
);

  localparam int unsigned IdxW   = $clog2(MAX_MESSAGES);
  localparam int unsigned BytesW = $clog2(QUEUE_BYTES + 1);
  localparam int unsigned CmpW   = ((BytesW > 11) ? BytesW : 11) + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_MESSAGES - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_MESSAGES);
  localparam logic [CmpW-1:0] BudgetC = CmpW'(QUEUE_BYTES);

  // Engine state
  logic [31:0]       now_q, now_d, last_send_q, last_send_d, last_rcv_q, last_rcv_d;
  logic [19:0]       ival_q, ival_d;
  logic [15:0]       att_q, att_d;
  logic [31:0]       retries_q, retries_d;
  logic [SeqW-1:0]   tx_seq_q, tx_seq_d, rx_seq_q, rx_seq_d;
  logic              rx_seen_q, rx_seen_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // Length store and registered head length
  logic [LenW-1:0]   len_mem [MAX_MESSAGES];
  logic [LenW-1:0]   head_len_q;
  logic              mem_we;

  // Result beat
  logic                out_valid_q;
  action_e             act_q, act_d;
  logic [SeqW-1:0]     oseq_q, oseq_d;
  logic                link_q, link_d;

  logic              fire;
  logic [22:0]       ival_x6;
  logic [46:0]       prod;
  logic [20:0]       grown;
  logic [15:0]       delta;
  logic signed [16:0] delta_s, neg_tol;
  logic [CmpW-1:0]   room, need, used, bytes_x;
  logic [31:0]       since_rcv;

  assign fire       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = fire;

  // Backoff: floor(interval * 6 / 5) by reciprocal multiply
  assign ival_x6 = {1'b0, ival_q, 2'b00} + {2'b00, ival_q, 1'b0};
  assign prod    = 47'(ival_x6) * 47'(RecipFive);
  assign grown   = prod[RecipShift +: 21];

  // Duplicate check operands
  assign delta   = item_i.seq - rx_seq_q;
  assign delta_s = $signed({delta[15], delta});
  assign neg_tol = -$signed({2'b00, cfg_i.dup_tol});

  // Budget operands
  assign bytes_x = CmpW'(bytes_q);
  assign room    = BudgetC - bytes_x;
  assign need    = CmpW'(item_i.len) + CmpW'(HeaderBytes);
  assign used    = CmpW'(head_len_q) + CmpW'(HeaderBytes);

  // Next state of the engine
  always_comb begin
    now_d       = now_q;
    last_send_d = last_send_q;
    last_rcv_d  = last_rcv_q;
    ival_d      = ival_q;
    att_d       = att_q;
    retries_d   = retries_q;
    tx_seq_d    = tx_seq_q;
    rx_seq_d    = rx_seq_q;
    rx_seen_d   = rx_seen_q;
    bytes_d     = bytes_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    act_d       = ACT_NONE;
    oseq_d      = '0;
    if (fire) begin
      case (item_i.op)
        OP_TICK: begin
          now_d = now_q + 32'd1;
          if (cnt_q != '0 && item_i.peer && (now_d - last_send_q) > {12'd0, ival_q}) begin
            last_send_d = now_d;
            if (att_q != 16'd0) begin
              retries_d = retries_q + 32'd1;
            end
            if (att_q != 16'hFFFF) begin
              att_d = att_q + 16'd1;
            end
            ival_d = (grown > {1'b0, cfg_i.retry_cap}) ? cfg_i.retry_cap : grown[19:0];
            act_d  = ACT_SEND;
            oseq_d = tx_seq_q;
          end
        end
        OP_ACK: begin
          last_rcv_d = now_q;
          oseq_d     = item_i.seq;
          if (cnt_q != '0 && item_i.seq == tx_seq_q) begin
            bytes_d     = (used > bytes_x) ? '0 : BytesW'(bytes_x - used);
            head_d      = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
            cnt_d       = cnt_q - CntW'(1);
            tx_seq_d    = tx_seq_q + 16'd1;
            last_send_d = now_q - AckBackdateMs;
            ival_d      = {4'd0, cfg_i.retry_floor};
            att_d       = 16'd0;
            act_d       = ACT_DELIVERED;
          end else begin
            act_d = ACT_ACK_IGN;
          end
        end
        OP_DATA: begin
          last_rcv_d = now_q;
          oseq_d     = item_i.seq;
          if (!rx_seen_q || delta_s > 17'sd0 || delta_s < neg_tol) begin
            rx_seen_d = 1'b1;
            rx_seq_d  = item_i.seq;
            act_d     = ACT_ACK_NEW;
          end else begin
            act_d = ACT_ACK_DUP;
          end
        end
        OP_ENQ: begin
          if (item_i.len != '0 && room > need && cnt_q < MaxCnt) begin
            mem_we  = 1'b1;
            tail_d  = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
            cnt_d   = cnt_q + CntW'(1);
            bytes_d = BytesW'(bytes_x + need);
            act_d   = ACT_QUEUED;
          end else begin
            act_d = ACT_FULL;
          end
        end
        OP_FLUSH: begin
          head_d  = '0;
          tail_d  = '0;
          cnt_d   = '0;
          bytes_d = '0;
        end
        default: begin
          act_d = ACT_NONE;
        end
      endcase
    end
  end

  // Link status after this item
  assign since_rcv = now_d - last_rcv_d;
  assign link_d    = item_i.peer && (since_rcv < {12'd0, cfg_i.link_timeout});

  // Length store: written at the tail, read ahead at the next head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      len_mem[tail_q] <= item_i.len;
    end
    if (mem_we && tail_q == head_d) begin
      head_len_q <= item_i.len;
    end else begin
      head_len_q <= len_mem[head_d];
    end
  end

  // Engine state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_send_q <= '0;
      last_rcv_q  <= '0;
      ival_q      <= {4'd0, MinRetryRst};
      att_q       <= '0;
      retries_q   <= '0;
      tx_seq_q    <= '0;
      rx_seq_q    <= '0;
      rx_seen_q   <= 1'b0;
      bytes_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
    end else begin
      now_q       <= now_d;
      last_send_q <= last_send_d;
      last_rcv_q  <= last_rcv_d;
      ival_q      <= ival_d;
      att_q       <= att_d;
      retries_q   <= retries_d;
      tx_seq_q    <= tx_seq_d;
      rx_seq_q    <= rx_seq_d;
      rx_seen_q   <= rx_seen_d;
      bytes_q     <= bytes_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
    end
  end

  // Result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      act_q  <= act_d;
      oseq_q <= oseq_d;
      link_q <= link_d;
    end
  end

  // Counters in the beat are the state after the item
  logic [15:0]     att_o_q;
  logic [31:0]     ret_o_q;
  logic [CntW-1:0] cnt_o_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      att_o_q <= att_d;
      ret_o_q <= retries_d;
      cnt_o_q <= cnt_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign action_o           = act_q;
  assign out_seq_o          = oseq_q;
  assign attempt_count_o    = att_o_q;
  assign total_retries_o    = ret_o_q;
  assign link_up_o          = link_q;
  assign pending_messages_o = cnt_o_q;

endmodule

@@ hdl/stop_and_wait_arq_engine_unit.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_engine_unit
// Sequencing core of a stop-and-wait reliable datagram link.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries events: millisecond tick,
//   ack received, data received, enqueue message length, flush queue.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result beat
//   per event: action, sequence, attempt and retry counts, link status and
//   queue depth after the event.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i);
//   write it only while the block is idle, which the block does not enforce.
// Throughput:
//   One event per cycle sustained while out_ready_i stays high. An accepted
//   event waits in the front queue, and the execute stage, a single step,
//   registers its result beat.
// Reset: queue empty, timers and counters zero, registers at their defaults.
// Stall: when out_ready_i is low the result beat holds; the two-entry front
//   queue keeps accepting until it fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_engine_unit import sawa_pkg::*; #(
  parameter int unsigned QUEUE_BYTES  = QueueBytesDef,
  parameter int unsigned MAX_MESSAGES = MaxMessagesDef,
  localparam int unsigned CntW = $clog2(MAX_MESSAGES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [SeqW-1:0]     seq_i,
  input  logic [LenW-1:0]     msg_length_i,
  input  logic                peer_known_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ActionW-1:0]  action_o,
  output logic [SeqW-1:0]     out_seq_o,
  output logic [15:0]         attempt_count_o,
  output logic [31:0]         total_retries_o,
  output logic                link_up_o,
  output logic [CntW-1:0]     pending_messages_o
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_floor  <= MinRetryRst;
      cfg_q.retry_cap    <= MaxRetryRst;
      cfg_q.dup_tol      <= DupTolRst;
      cfg_q.link_timeout <= LinkTimeoutRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RETRY_FLOOR:  cfg_q.retry_floor  <= cfg_data_i[15:0];
        REG_RETRY_CAP:    cfg_q.retry_cap    <= cfg_data_i;
        REG_DUP_TOL:      cfg_q.dup_tol      <= cfg_data_i[14:0];
        REG_LINK_TIMEOUT: cfg_q.link_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sawa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .seq_i        (seq_i),
    .msg_length_i (msg_length_i),
    .peer_known_i (peer_known_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  sawa_back #(
    .QUEUE_BYTES  (QUEUE_BYTES),
    .MAX_MESSAGES (MAX_MESSAGES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .item_valid_i       (item_valid),
    .item_pop_o         (item_pop),
    .item_i             (item),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .action_o           (action_o),
    .out_seq_o          (out_seq_o),
    .attempt_count_o    (attempt_count_o),
    .total_retries_o    (total_retries_o),
    .link_up_o          (link_up_o),
    .pending_messages_o (pending_messages_o)
  );

endmodule

@@ hdl/sawa_checker.sv @@
// ----------------------------------------------------------------------------
// sawa_checker
// Port-level checks of the ARQ engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sawa_checker import sawa_pkg::*; #(
  parameter int unsigned MAX_MESSAGES = MaxMessagesDef,
  localparam int unsigned CntW = $clog2(MAX_MESSAGES + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ActionW-1:0] action_o,
  input logic [SeqW-1:0]    out_seq_o,
  input logic [15:0]        attempt_count_o,
  input logic [CntW-1:0]    pending_messages_o
);

  // A stalled result beat stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Queue depth never exceeds its capacity
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_messages_o <= CntW'(MAX_MESSAGES))
    else $error("pending count above capacity");

  // Delivered head clears the attempt count
  a_deliv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_DELIVERED |-> attempt_count_o == 16'd0)
    else $error("attempts not cleared on delivery");

  // Sending always counts at least one attempt, and no-sequence actions carry zero
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_NONE || action_o == ACT_QUEUED ||
                    action_o == ACT_FULL) |-> out_seq_o == '0)
    else $error("sequence on an action that carries none");

  a_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_SEND |-> attempt_count_o != 16'd0 &&
                                            pending_messages_o != '0)
    else $error("send without queued head or attempt");

endmodule

bind stop_and_wait_arq_engine_unit sawa_checker #(
  .MAX_MESSAGES (MAX_MESSAGES)
) u_sawa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .action_o           (action_o),
  .out_seq_o          (out_seq_o),
  .attempt_count_o    (attempt_count_o),
  .pending_messages_o (pending_messages_o)
);

@@ sim/stop_and_wait_arq_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_engine_unit_test
// Self-checking bench for the stop-and-wait ARQ engine. Events are driven
// on the input channel with random gaps, and results are taken with random
// stalls. Each result beat is compared field by field against a cycle-free
// model of the queue, sequencing, backoff, duplicate and link logic, under
// several register settings.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_engine_unit_test;
  import sawa_pkg::*;

  localparam int unsigned  CycleLimit = 3000000;
  localparam int unsigned  QBytes     = QueueBytesDef;
  localparam int unsigned  QMsgs      = MaxMessagesDef;
  localparam logic [2:0]   KindBadLo  = 3'd5;
  localparam logic [2:0]   KindBadHi  = 3'd7;

  typedef struct {
    action_e     action;
    logic [15:0] seq;
    logic [15:0] attempts;
    logic [31:0] retries;
    logic        link;
    logic [6:0]  pending;
  } result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [KindW-1:0]  kind_i = '0;
  logic [SeqW-1:0]   seq_i = '0;
  logic [LenW-1:0]   msg_length_i = '0;
  logic              peer_known_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ActionW-1:0] action_o;
  logic [SeqW-1:0]   out_seq_o;
  logic [15:0]       attempt_count_o;
  logic [31:0]       total_retries_o;
  logic              link_up_o;
  logic [6:0]        pending_messages_o;

  stop_and_wait_arq_engine_unit u_dut (.*);

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Model state
  logic [15:0] m_retry_floor;
  logic [19:0] m_retry_cap;
  logic [14:0] m_dup_tol;
  logic [19:0] m_link_timeout;
  logic [31:0] m_now, m_last_send, m_last_rx_time;
  logic [19:0] m_interval;
  logic [15:0] m_attempts;
  logic [31:0] m_retries;
  logic [15:0] m_tx_seq, m_rx_seq;
  logic        m_rx_seen;
  logic [10:0] m_bytes;
  logic [9:0]  m_lengths [QMsgs];
  logic [5:0]  m_head;
  logic [6:0]  m_count;

  result_t     expected_results [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned next_gap = 0;
  bit          burst = 1'b0;
  bit          out_burst = 1'b0;

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp_v, got_v, cycles);
    errors++;
  endtask

  // Model of one event; returns the result it causes
  function automatic result_t engine_step(logic [2:0] kind, logic [15:0] seq,
                                          logic [9:0] len, logic peer);
    result_t     r;
    logic [31:0] grown, used, room;
    logic [15:0] diff;
    int          delta;
    r.action = ACT_NONE;
    r.seq    = '0;
    case (kind)
      EV_TICK: begin
        m_now++;
        if (m_count != 0 && peer && (m_now - m_last_send) > 32'(m_interval)) begin
          m_last_send = m_now;
          if (m_attempts != 0) m_retries++;
          if (m_attempts != 16'hFFFF) m_attempts++;
          grown = 32'(m_interval) * 6 / 5;
          if (grown > 32'(m_retry_cap)) grown = 32'(m_retry_cap);
          m_interval = grown[19:0];
          r.action = ACT_SEND;
          r.seq    = m_tx_seq;
        end
      end
      EV_ACK: begin
        m_last_rx_time = m_now;
        r.seq = seq;
        if (m_count != 0 && seq == m_tx_seq) begin
          used = 32'(m_lengths[m_head]) + 2;
          m_bytes = (used > 32'(m_bytes)) ? '0 : m_bytes - used[10:0];
          m_head++;
          m_count--;
          m_tx_seq++;
          m_last_send = m_now - AckBackdateMs;
          m_interval  = 20'(m_retry_floor);
          m_attempts  = '0;
          r.action = ACT_DELIVERED;
        end else begin
          r.action = ACT_ACK_IGN;
        end
      end
      EV_DATA: begin
        diff  = seq - m_rx_seq;
        delta = int'($signed(diff));
        m_last_rx_time = m_now;
        r.seq = seq;
        if (!m_rx_seen || delta > 0 || delta < -int'(m_dup_tol)) begin
          m_rx_seen = 1'b1;
          m_rx_seq  = seq;
          r.action  = ACT_ACK_NEW;
        end else begin
          r.action = ACT_ACK_DUP;
        end
      end
      EV_ENQ: begin
        room = (QBytes > 32'(m_bytes)) ? QBytes - 32'(m_bytes) : 0;
        if (len != 0 && room > 32'(len) + 2 && m_count < QMsgs) begin
          m_lengths[6'(m_head + m_count)] = len;
          m_count++;
          m_bytes += 11'(len) + HeaderBytes;
          r.action = ACT_QUEUED;
        end else begin
          r.action = ACT_FULL;
        end
      end
      EV_FLUSH: begin
        m_head  = '0;
        m_count = '0;
        m_bytes = '0;
      end
      default: ;
    endcase
    r.attempts = m_attempts;
    r.retries  = m_retries;
    r.link     = peer && ((m_now - m_last_rx_time) < 32'(m_link_timeout));
    r.pending  = m_count;
    return r;
  endfunction

  // Send one event beat and queue its expected result
  task automatic send_event(input logic [2:0] kind, input logic [15:0] seq,
                            input logic [9:0] len, input logic peer);
    repeat (next_gap) @(posedge clk_i);
    kind_i       <= kind;
    seq_i        <= seq;
    msg_length_i <= len;
    peer_known_i <= peer;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(engine_step(kind, seq, len, peer));
    next_gap = burst ? 0 : $urandom_range(0, 16);
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  // Drain all results, then let the pipeline go quiet
  task automatic settle();
    if (next_gap == 0) in_valid_i <= 1'b0;
    next_gap = 1;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [19:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_RETRY_FLOOR:  m_retry_floor  = value[15:0];
      REG_RETRY_CAP:    m_retry_cap    = value;
      REG_DUP_TOL:      m_dup_tol      = value[14:0];
      REG_LINK_TIMEOUT: m_link_timeout = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [19:0] min_r, input logic [19:0] max_r,
                           input logic [19:0] tol, input logic [19:0] link_t);
    settle();
    write_reg(REG_RETRY_FLOOR, min_r);
    write_reg(REG_RETRY_CAP, max_r);
    write_reg(REG_DUP_TOL, tol);
    write_reg(REG_LINK_TIMEOUT, link_t);
  endtask

  // Result checker with random back-pressure
  initial begin : result_check
    int unsigned stall;
    result_t     e;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 1);
        end else begin
          e = expected_results.pop_front();
          if (action_o != e.action) report_mismatch("action", e.action, action_o);
          if (out_seq_o != e.seq) report_mismatch("out_seq", e.seq, out_seq_o);
          if (attempt_count_o != e.attempts)
            report_mismatch("attempt_count", e.attempts, attempt_count_o);
          if (total_retries_o != e.retries)
            report_mismatch("total_retries", e.retries, total_retries_o);
          if (link_up_o != e.link) report_mismatch("link_up", e.link, link_up_o);
          if (pending_messages_o != e.pending)
            report_mismatch("pending_messages", e.pending, pending_messages_o);
        end
        stall = out_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Tests
  task automatic test_queue_admission();
    send_event(EV_TICK, 16'h0000, 10'd0, 1'b1);   // empty queue, no send
    send_event(EV_ENQ, 16'hFFFF, 10'd0, 1'b0);    // zero length refused
    send_event(EV_ENQ, 16'h0000, 10'd1021, 1'b1); // largest length accepted into the byte budget
    send_event(EV_ENQ, 16'h0000, 10'd1, 1'b1);    // no room left
    send_event(EV_FLUSH, 16'h0000, 10'd0, 1'b1);
    send_event(EV_ENQ, 16'h0000, 10'd1023, 1'b1); // too long for empty budget
    send_event(EV_ENQ, 16'h0000, 10'd1022, 1'b1);
    send_event(EV_FLUSH, 16'h0000, 10'd0, 1'b0);
    // message count limit
    for (int i = 0; i < QMsgs + 1; i++) send_event(EV_ENQ, 16'h0, 10'd1, 1'b1);
    send_event(EV_FLUSH, 16'h0000, 10'd0, 1'b1);
  endtask

  task automatic test_ack_path();
    send_event(EV_ACK, 16'h0000, 10'd0, 1'b1);    // empty queue: ignored
    send_event(EV_ENQ, 16'h0000, 10'd512, 1'b1);
    send_event(EV_ENQ, 16'h0000, 10'd3, 1'b1);
    send_event(EV_ACK, 16'h8001, 10'd0, 1'b1);    // mismatch
    send_event(EV_ACK, m_tx_seq, 10'd0, 1'b0);    // delivered
    send_event(EV_TICK, 16'h0, 10'd0, 1'b1);      // backdated send goes out
    send_event(EV_ACK, m_tx_seq, 10'd0, 1'b1);
    send_event(EV_ACK, m_tx_seq, 10'd0, 1'b1);    // queue empty again
  endtask

  task automatic test_duplicates();
    send_event(EV_DATA, 16'h0000, 10'd0, 1'b1);   // first data is new
    send_event(EV_DATA, 16'h0000, 10'd0, 1'b1);   // same: duplicate
    send_event(EV_DATA, 16'h0001, 10'd0, 1'b1);
    send_event(EV_DATA, 16'hFFF7, 10'd0, 1'b1);   // 10 behind: duplicate
    send_event(EV_DATA, 16'hFFF6, 10'd0, 1'b1);   // 11 behind: new
    send_event(EV_DATA, 16'h7FF6, 10'd0, 1'b1);   // +32768 reads as behind
    send_event(EV_DATA, 16'hFFFF, 10'd0, 1'b0);
  endtask

  task automatic test_unknown_kinds();
    for (logic [3:0] k = 4'(KindBadLo); k <= 4'(KindBadHi); k++)
      send_event(k[2:0], 16'hFFFF, 10'h3FF, 1'b1);
  endtask

  task automatic test_backoff();
    configure(20'd1, 20'd9, 20'd0, 20'd1);
    send_event(EV_ENQ, 16'h0, 10'd7, 1'b1);
    for (int i = 0; i < 40; i++) send_event(EV_TICK, 16'h0, 10'd0, i % 9 != 4);
    send_event(EV_DATA, 16'h1234, 10'd0, 1'b1);
    send_event(EV_TICK, 16'h0, 10'd0, 1'b1);
    send_event(EV_ACK, m_tx_seq, 10'd0, 1'b1);
    send_event(EV_FLUSH, 16'h0, 10'd0, 1'b1);
  endtask

  // Mostly well-formed traffic around the live sequences, some noise
  task automatic test_random(input int unsigned count);
    logic [15:0] seq;
    logic [9:0]  len;
    logic [2:0]  kind;
    int unsigned pick, span;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 63) == 0) burst = ~burst;
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      pick = $urandom_range(0, 99);
      seq  = 16'($urandom);
      len  = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
      if (pick < 42) kind = EV_TICK;
      else if (pick < 62) begin
        kind = EV_ACK;
        if ($urandom_range(0, 3) != 0) seq = m_tx_seq;
        else if ($urandom_range(0, 1) != 0) seq = m_tx_seq + 1;
      end else if (pick < 77) begin
        kind = EV_DATA;
        span = (m_dup_tol > 40) ? 40 : int'(m_dup_tol) + 4;
        if ($urandom_range(0, 4) != 0)
          seq = m_rx_seq + 16'($urandom_range(0, 2 * span)) - 16'(span);
      end else if (pick < 95) kind = EV_ENQ;
      else if (pick < 97) kind = EV_FLUSH;
      else kind = 3'($urandom_range(KindBadLo, KindBadHi));
      send_event(kind, seq, len, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin : main
    m_retry_floor = MinRetryRst;
    m_retry_cap = MaxRetryRst;
    m_dup_tol = DupTolRst;
    m_link_timeout = LinkTimeoutRst;
    m_now = '0; m_last_send = '0; m_last_rx_time = '0;
    m_interval = 20'(MinRetryRst);
    m_attempts = '0; m_retries = '0;
    m_tx_seq = '0; m_rx_seq = '0; m_rx_seen = 1'b0;
    m_bytes = '0; m_head = '0; m_count = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_queue_admission();
    test_ack_path();
    test_duplicates();
    test_unknown_kinds();
    test_random(200);
    test_backoff();
    test_random(450);
    configure(20'd65535, 20'd1000000, 20'd32767, 20'd1000000);
    test_random(200);
    configure(20'd50, 20'd5, 20'd3, 20'd20);
    test_random(300);
    configure(20'd4, 20'd200, 20'd10, 20'd60);
    test_random(400);

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
